// ===== sv/mlsu_pkg.sv =====
// Shared constants, codes and types for the mutex lock state unit.
package mlsu_pkg;

   localparam int ID_BITS_DEF    = 16;
   localparam int DEPTH_BITS_DEF = 8;
   localparam int ACTION_BITS    = 2;
   localparam int KIND_BITS      = 2;
   localparam int STATUS_BITS    = 3;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_LOCK   = 2'd0,
      ACT_TRY    = 2'd1,
      ACT_UNLOCK = 2'd2,
      ACT_RSVD   = 2'd3
   } action_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_NORMAL    = 2'd0,
      KIND_ERRCHK    = 2'd1,
      KIND_RECURSIVE = 2'd2,
      KIND_RSVD      = 2'd3
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK       = 3'd0,
      ST_BUSY     = 3'd1,
      ST_WAIT     = 3'd2,
      ST_DEADLOCK = 3'd3,
      ST_NOPERM   = 3'd4
   } status_type;

   typedef struct packed {
      status_type status;
      logic       wake;
   } rsp_flags_type;

endpackage

// ===== sv/mlsu_decide.sv =====
// Decision logic that applies one request to the mutex state.
module mlsu_decide #(
   parameter int ID_BITS    = mlsu_pkg::ID_BITS_DEF,
   parameter int DEPTH_BITS = mlsu_pkg::DEPTH_BITS_DEF
) (
   input  mlsu_pkg::kind_type      lock_kind,
   input  mlsu_pkg::action_type    action,
   input  logic [ID_BITS-1:0]      requester_id,
   input  logic                    held,
   input  logic [ID_BITS-1:0]      owner,
   input  logic [DEPTH_BITS-1:0]   depth,
   output logic                    held_next,
   output logic [ID_BITS-1:0]      owner_next,
   output logic [DEPTH_BITS-1:0]   depth_next,
   output mlsu_pkg::rsp_flags_type flags
);
   import mlsu_pkg::*;

   logic mine;
   logic is_rec;
   logic is_chk;
   logic is_normal;

   assign mine      = held && (owner == requester_id);
   assign is_rec    = (lock_kind == KIND_RECURSIVE);
   assign is_chk    = (lock_kind == KIND_ERRCHK);
   assign is_normal = !is_rec && !is_chk;

   always_comb begin
      held_next    = held;
      owner_next   = owner;
      depth_next   = depth;
      flags.status = ST_OK;
      flags.wake   = 1'b0;
      unique case (action)
         ACT_LOCK, ACT_TRY: begin
            if (!held) begin
               held_next  = 1'b1;
               owner_next = requester_id;
               depth_next = '0;
            end else if (mine && is_rec) begin
               if (!(&depth)) begin
                  depth_next = depth + 1'b1;
               end
            end else if (action == ACT_TRY) begin
               flags.status = ST_BUSY;
            end else if (mine && is_chk) begin
               flags.status = ST_DEADLOCK;
            end else begin
               flags.status = ST_WAIT;
            end
         end
         ACT_UNLOCK: begin
            if (is_normal) begin
               if (held) begin
                  held_next  = 1'b0;
                  owner_next = '0;
                  depth_next = '0;
                  flags.wake = 1'b1;
               end
            end else if (!mine) begin
               flags.status = ST_NOPERM;
            end else if (is_rec && (depth != '0)) begin
               depth_next = depth - 1'b1;
            end else begin
               held_next  = 1'b0;
               owner_next = '0;
               depth_next = '0;
               flags.wake = 1'b1;
            end
         end
         default: begin
            flags.status = ST_NOPERM;
         end
      endcase
   end

endmodule

// ===== sv/mutex_lock_state_unit.sv =====
// Top level of the mutex lock state unit: request register, state and result register.
// A request beat passes through the request register, then the result register.
// Throughput: one request per cycle while rsp_tready stays high.
// The mutex state is updated as a request moves from the request register to the result
// register, so back-to-back requests see each other's effect in order.
// Reset clears both valid flags, the lock kind, and frees the mutex (owner 0, depth 0).
module mutex_lock_state_unit #(
   parameter int ID_BITS    = mlsu_pkg::ID_BITS_DEF,
   parameter int DEPTH_BITS = mlsu_pkg::DEPTH_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // Fields from bit 0 up: action, requester_id, zero padding.
   input  logic [((ID_BITS+mlsu_pkg::ACTION_BITS+7)/8)*8-1:0] req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // Fields from bit 0 up: status, wake_waiters, holder_id, zero padding.
   output logic [((ID_BITS+mlsu_pkg::STATUS_BITS+8)/8)*8-1:0] rsp_tdata,
   input  logic                                   csr_wr_en,
   input  logic [mlsu_pkg::KIND_BITS-1:0]         csr_wr_data
);
   import mlsu_pkg::*;

   localparam int RSP_BITS = ((ID_BITS + STATUS_BITS + 8) / 8) * 8;
   localparam int RSP_USED = ID_BITS + STATUS_BITS + 1;

   kind_type              kind_ff;
   logic                  req_vld_ff;
   action_type            req_action_ff;
   logic [ID_BITS-1:0]    req_id_ff;
   logic                  rsp_vld_ff;
   rsp_flags_type         rsp_flags_ff;
   logic [ID_BITS-1:0]    rsp_holder_ff;
   logic                  held_ff;
   logic [ID_BITS-1:0]    owner_ff;
   logic [DEPTH_BITS-1:0] depth_ff;

   logic                  held_in;
   logic [ID_BITS-1:0]    owner_in;
   logic [DEPTH_BITS-1:0] depth_in;
   rsp_flags_type         flags_in;
   logic                  rsp_free;
   logic                  advance;
   logic                  req_take;

   assign rsp_free   = !rsp_vld_ff || rsp_tready;
   assign advance    = req_vld_ff && rsp_free;
   assign req_tready = !req_vld_ff || rsp_free;
   assign req_take   = req_tvalid && req_tready;

   mlsu_decide #(
      .ID_BITS   (ID_BITS),
      .DEPTH_BITS(DEPTH_BITS)
   ) u_decide (
      .lock_kind   (kind_ff),
      .action      (req_action_ff),
      .requester_id(req_id_ff),
      .held        (held_ff),
      .owner       (owner_ff),
      .depth       (depth_ff),
      .held_next   (held_in),
      .owner_next  (owner_in),
      .depth_next  (depth_in),
      .flags       (flags_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= KIND_NORMAL;
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         held_ff    <= 1'b0;
         owner_ff   <= '0;
         depth_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            kind_ff <= kind_type'(csr_wr_data);
         end
         if (req_tready) begin
            req_vld_ff <= req_tvalid;
         end
         if (rsp_free) begin
            rsp_vld_ff <= req_vld_ff;
         end
         if (advance) begin
            held_ff  <= held_in;
            owner_ff <= owner_in;
            depth_ff <= depth_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_action_ff <= action_type'(req_tdata[ACTION_BITS-1:0]);
         req_id_ff     <= req_tdata[ACTION_BITS +: ID_BITS];
      end
      if (advance) begin
         rsp_flags_ff  <= flags_in;
         rsp_holder_ff <= held_in ? owner_in : '0;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = RSP_BITS'({rsp_holder_ff, rsp_flags_ff.wake, rsp_flags_ff.status});

   if (RSP_USED > RSP_BITS) begin : g_bad_width
      $error("Result packing does not fit.");
   end

endmodule

// ===== sv/mlsu_checker.sv =====
// Port-level checker for the mutex lock state unit and its bind statement.
module mlsu_checker #(
   parameter int ID_BITS = mlsu_pkg::ID_BITS_DEF
) (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_tready,
   input logic                                   rsp_tvalid,
   input logic                                   rsp_tready,
   input logic [((ID_BITS+mlsu_pkg::STATUS_BITS+8)/8)*8-1:0] rsp_tdata
);
   import mlsu_pkg::*;

   logic [STATUS_BITS-1:0] status;
   logic                   wake;
   logic [ID_BITS-1:0]     holder;

   assign status = rsp_tdata[STATUS_BITS-1:0];
   assign wake   = rsp_tdata[STATUS_BITS];
   assign holder = rsp_tdata[STATUS_BITS+1 +: ID_BITS];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled result beat changed.");

   a_wake_free: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && wake |-> (status == ST_OK) && (holder == '0))
      else $error("Wake reported without a clean release.");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("Result valid right after reset.");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("Request stalled while the result side is empty.");

endmodule

bind mutex_lock_state_unit mlsu_checker #(
   .ID_BITS(ID_BITS)
) u_mlsu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

// ===== tb/mutex_lock_state_unit_test.sv =====
// Self-checking testbench for the mutex lock state unit, with request and result streams.
`timescale 1ns / 100ps

module mutex_lock_state_unit_test;
   import mlsu_pkg::*;

   localparam int ID_W = ID_BITS_DEF;
   localparam int DEPTH_W = DEPTH_BITS_DEF;
   localparam int REQ_W = ((ID_W + ACTION_BITS + 7) / 8) * 8;
   localparam int RSP_W = ((ID_W + STATUS_BITS + 8) / 8) * 8;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 4;

   typedef struct {
      status_type      status;
      logic            wake;
      logic [ID_W-1:0] holder;
   } mutex_outcome_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   // Fields from bit 0 up: action, requester_id, zero padding.
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   // Fields from bit 0 up: status, wake_waiters, holder_id, zero padding.
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_wr_en;
   logic [KIND_BITS-1:0] csr_wr_data;

   logic               lock_held = 1'b0;
   logic [ID_W-1:0]    lock_owner = '0;
   logic [DEPTH_W-1:0] lock_depth = '0;
   kind_type           lock_kind_now = KIND_NORMAL;

   mutex_outcome_type pending_results[$];
   mutex_outcome_type want_result;
   int  fault_count = 0;
   int  quiet_cycles = 0;
   int  rsp_hold_cycles = 0;
   bit  tx_gaps_on = 1'b1;
   bit  rx_gaps_on = 1'b1;

   mutex_lock_state_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic mutex_outcome_type resolve_request(input action_type act,
                                                         input logic [ID_W-1:0] who);
      mutex_outcome_type r;
      kind_type          rules;
      logic              mine;
      r.status = ST_OK;
      r.wake = 1'b0;
      rules = (lock_kind_now == KIND_ERRCHK || lock_kind_now == KIND_RECURSIVE) ?
              lock_kind_now : KIND_NORMAL;
      mine = lock_held && (lock_owner == who);
      case (act)
         ACT_LOCK, ACT_TRY: begin
            if (!lock_held) begin
               lock_held = 1'b1;
               lock_owner = who;
               lock_depth = '0;
            end else if (mine && rules == KIND_RECURSIVE) begin
               if (lock_depth != '1) lock_depth = lock_depth + 1'b1;
            end else if (act == ACT_TRY) begin
               r.status = ST_BUSY;
            end else if (mine && rules == KIND_ERRCHK) begin
               r.status = ST_DEADLOCK;
            end else begin
               r.status = ST_WAIT;
            end
         end
         ACT_UNLOCK: begin
            if (rules == KIND_NORMAL) begin
               if (lock_held) begin
                  lock_held = 1'b0;
                  lock_owner = '0;
                  lock_depth = '0;
                  r.wake = 1'b1;
               end
            end else if (!mine) begin
               r.status = ST_NOPERM;
            end else if (rules == KIND_RECURSIVE && lock_depth != '0) begin
               lock_depth = lock_depth - 1'b1;
            end else begin
               lock_held = 1'b0;
               lock_owner = '0;
               lock_depth = '0;
               r.wake = 1'b1;
            end
         end
         default: begin
            r.status = ST_NOPERM;
         end
      endcase
      r.holder = lock_held ? lock_owner : '0;
      return r;
   endfunction

   task automatic send_request(input action_type act, input logic [ID_W-1:0] who);
      int gap;
      gap = tx_gaps_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'({who, act});
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(resolve_request(act, who));
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_lock_kind(input kind_type k);
      wait_for_drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= k;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      lock_kind_now = k;
   endtask

   task automatic test_normal_rules();
      send_request(ACT_UNLOCK, 16'h0001);
      send_request(ACT_LOCK, 16'h0001);
      send_request(ACT_TRY, 16'hFFFF);
      send_request(ACT_LOCK, 16'h0001);
      send_request(ACT_UNLOCK, 16'hFFFF);
      send_request(ACT_RSVD, 16'h0005);
      send_request(ACT_TRY, 16'hFFFF);
      send_request(ACT_UNLOCK, 16'hFFFF);
   endtask

   task automatic test_error_check_rules();
      write_lock_kind(KIND_ERRCHK);
      send_request(ACT_UNLOCK, 16'h0003);
      send_request(ACT_LOCK, 16'hAAAA);
      send_request(ACT_LOCK, 16'hAAAA);
      send_request(ACT_TRY, 16'hAAAA);
      send_request(ACT_UNLOCK, 16'h5555);
      send_request(ACT_UNLOCK, 16'hAAAA);
   endtask

   task automatic test_recursive_rules();
      write_lock_kind(KIND_RECURSIVE);
      send_request(ACT_TRY, 16'h1234);
      send_request(ACT_LOCK, 16'h1234);
      send_request(ACT_TRY, 16'h1234);
      send_request(ACT_LOCK, 16'h0007);
      send_request(ACT_UNLOCK, 16'h0007);
      send_request(ACT_UNLOCK, 16'h1234);
      send_request(ACT_UNLOCK, 16'h1234);
      send_request(ACT_UNLOCK, 16'h1234);
   endtask

   task automatic test_kind_change_while_held();
      send_request(ACT_LOCK, 16'h0009);
      send_request(ACT_LOCK, 16'h0009);
      write_lock_kind(KIND_RSVD);
      send_request(ACT_LOCK, 16'h0009);
      send_request(ACT_UNLOCK, 16'h0000);
      send_request(ACT_LOCK, 16'h0000);
      send_request(ACT_UNLOCK, 16'h8000);
   endtask

   task automatic test_depth_saturation();
      logic [ID_W-1:0] who;
      int              i;
      who = ID_W'($urandom_range(1, 65535));
      tx_gaps_on = 1'b0;
      rx_gaps_on = 1'b0;
      write_lock_kind(KIND_RECURSIVE);
      send_request(ACT_LOCK, who);
      for (i = 0; i < 262; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            send_request(action_type'($urandom_range(0, 3)),
                         who ^ (16'd1 << $urandom_range(0, 15)));
         end
         send_request($urandom_range(0, 1) ? ACT_LOCK : ACT_TRY, who);
         if (i == 150) begin
            tx_gaps_on = 1'b1;
            rx_gaps_on = 1'b1;
         end
      end
      send_request(ACT_UNLOCK, who);
      send_request(ACT_UNLOCK, who);
      write_lock_kind(KIND_NORMAL);
      send_request(ACT_LOCK, who);
      send_request(ACT_UNLOCK, ~who);
   endtask

   task automatic test_random_sessions();
      kind_type        session_kinds[6];
      logic [ID_W-1:0] pool[3];
      logic [ID_W-1:0] who;
      action_type      act;
      int              s;
      int              n;
      int              pick;
      session_kinds[0] = KIND_RECURSIVE;
      session_kinds[1] = KIND_ERRCHK;
      session_kinds[2] = KIND_NORMAL;
      session_kinds[3] = KIND_RSVD;
      session_kinds[4] = kind_type'($urandom_range(0, 3));
      session_kinds[5] = kind_type'($urandom_range(0, 3));
      for (s = 0; s < 6; s++) begin
         write_lock_kind(session_kinds[s]);
         tx_gaps_on = (s == 2) ? 1'b0 : 1'($urandom_range(0, 1));
         rx_gaps_on = (s == 2) ? 1'b0 : 1'($urandom_range(0, 1));
         pool[0] = ID_W'($urandom);
         pool[1] = ID_W'($urandom);
         pool[2] = (s == 0) ? '0 : ((s == 1) ? '1 : ID_W'($urandom));
         for (n = 0; n < 75; n++) begin
            pick = $urandom_range(0, 99);
            who = (pick < 85) ? pool[2'($urandom_range(0, 2))] : ID_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 40) act = ACT_LOCK;
            else if (pick < 65) act = ACT_TRY;
            else if (pick < 97) act = ACT_UNLOCK;
            else act = ACT_RSVD;
            send_request(act, who);
         end
      end
      tx_gaps_on = 1'b1;
      rx_gaps_on = 1'b1;
   endtask

   task automatic test_backpressure();
      logic [ID_W-1:0] pair[2];
      int              n;
      pair[0] = ID_W'($urandom);
      pair[1] = ~pair[0];
      wait_for_drain();
      tx_gaps_on = 1'b0;
      rsp_hold_cycles = 80;
      for (n = 0; n < 40; n++) begin
         send_request(action_type'($urandom_range(0, 2)), pair[1'($urandom_range(0, 1))]);
      end
      wait_for_drain();
      tx_gaps_on = 1'b1;
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= KIND_NORMAL;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_normal_rules();
      test_error_check_rules();
      test_recursive_rules();
      test_kind_change_while_held();
      test_depth_saturation();
      test_backpressure();
      test_random_sessions();
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("mutex_lock_state_unit_test: done, clean");
      end else begin
         $display("mutex_lock_state_unit_test: done, errors");
      end
      $finish;
   end

   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = rx_gaps_on ? $urandom_range(0, 11) : 0;
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result beat with nothing expected, tdata 0x%0h", rsp_tdata);
            fault_count++;
         end else begin
            want_result = pending_results.pop_front();
            if (rsp_tdata[STATUS_BITS-1:0] !== want_result.status) begin
               $error("status: expected %0d, actual %0d", want_result.status,
                      rsp_tdata[STATUS_BITS-1:0]);
               fault_count++;
            end
            if (rsp_tdata[STATUS_BITS] !== want_result.wake) begin
               $error("wake_waiters: expected %0d, actual %0d", want_result.wake,
                      rsp_tdata[STATUS_BITS]);
               fault_count++;
            end
            if (rsp_tdata[STATUS_BITS+ID_W:STATUS_BITS+1] !== want_result.holder) begin
               $error("holder_id: expected 0x%0h, actual 0x%0h", want_result.holder,
                      rsp_tdata[STATUS_BITS+ID_W:STATUS_BITS+1]);
               fault_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("mutex_lock_state_unit_test: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ===== filelist.f =====
sv/mlsu_pkg.sv
sv/mlsu_decide.sv
sv/mutex_lock_state_unit.sv
sv/mlsu_checker.sv
tb/mutex_lock_state_unit_test.sv
